/* sv/path_oram_access_core_macros.svh */
// Assertion macros shared by the path ORAM access core.
`ifndef PATH_ORAM_ACCESS_CORE_MACROS_SVH
`define PATH_ORAM_ACCESS_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define POA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define POA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define POA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define POA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* sv/poa_pkg.sv */
// Package with the fixed field widths and the sequencer states of the path ORAM core.
package poa_pkg;

  localparam int ADDR_W    = 4;
  localparam int LEAF_IN_W = 3;
  localparam int DATA_W    = 64;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_LOOKUP,
    ST_INSERT,
    ST_EVICT,
    ST_PAD,
    ST_FINISH
  } state_e;

endpackage

/* sv/poa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module poa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/path_oram_access_core.sv */
// Path ORAM access core: position map, bucket tree RAM, stash RAM and access sequencer.
//
// After reset the core first sweeps the bucket tree to mark every slot empty; no request
// is taken meanwhile. One request then runs alone through a sequencer that owns a single
// read port on the tree RAM and one on the stash RAM. It fetches the path into the stash,
// looks the address up in the stash and inserts it there on a miss. Eviction then works
// level by level from the leaf up: it scans the stash and clears the unused slots of that
// bucket. A last step hands the result over. The result sits in an output register, so a
// finished access can wait there while the next request is accepted.
module path_oram_access_core #(
  parameter int TREE_LEVELS      = 4,
  parameter int SLOTS_PER_BUCKET = 4,
  parameter int BLOCK_BYTES      = 8,
  parameter int STASH_DEPTH      = 32,
  parameter int ADDRESS_COUNT    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic [poa_pkg::ADDR_W-1:0]     address_i,
  input  logic [poa_pkg::DATA_W-1:0]     write_data_i,
  input  logic [poa_pkg::LEAF_IN_W-1:0]  new_leaf_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [poa_pkg::DATA_W-1:0]     read_data_o,
  output logic                           stash_overflow_o
);

  `include "path_oram_access_core_macros.svh"

  localparam int LW         = TREE_LEVELS - 1;
  localparam int DW         = BLOCK_BYTES * 8;
  localparam int DEPW       = $clog2(TREE_LEVELS);
  localparam int NODE_COUNT = (2 ** TREE_LEVELS) - 1;
  localparam int SLOT_COUNT = NODE_COUNT * SLOTS_PER_BUCKET;
  localparam int SAW        = $clog2(SLOT_COUNT);
  localparam int ZW         = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int STW        = $clog2(STASH_DEPTH);
  localparam int FW         = $clog2(STASH_DEPTH + 1);
  localparam int MAP_DEPTH  = 2 ** poa_pkg::ADDR_W;

  typedef struct packed {
    logic [poa_pkg::ADDR_W-1:0] tag;
    logic [LW-1:0]              leaf;
    logic [DW-1:0]              data;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t ent;
  } slot_t;

  poa_pkg::state_e state_q, state_d;

  logic [LW-1:0]               leaf_map_q [MAP_DEPTH];
  logic [LW-1:0]               leaf_map_d [MAP_DEPTH];
  logic [SAW-1:0]              clr_q, clr_d;
  logic                        mode_q, mode_d;
  logic [poa_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic [DW-1:0]               wdata_q, wdata_d;
  logic [LW-1:0]               nleaf_q, nleaf_d;
  logic [LW-1:0]               x_q, x_d;
  logic [DEPW-1:0]             lvl_q, lvl_d;
  logic [ZW-1:0]               k_q, k_d;
  logic                        iss_done_q, iss_done_d;
  logic                        pend_q, pend_d;
  logic [FW-1:0]               idx_q, idx_d;
  logic [STW-1:0]              pos_q, pos_d;
  logic [FW-1:0]               w_q, w_d;
  logic [ZW-1:0]               n_q, n_d;
  logic                        hit_q, hit_d;
  logic [DW-1:0]               rdata_q, rdata_d;
  logic [FW-1:0]               fill_q, fill_d;
  logic                        ovf_q, ovf_d;
  logic                        out_valid_q, out_valid_d;
  logic [DW-1:0]               out_data_q, out_data_d;
  logic                        out_ovf_q, out_ovf_d;

  logic                        in_fire;
  logic [poa_pkg::ADDR_W-1:0]  addr_in;
  logic                        fetch_done;
  logic                        scan_done;
  logic                        pad_done;
  logic                        out_free;

  logic                        tree_we;
  logic [SAW-1:0]              tree_waddr;
  slot_t                       tree_wdata;
  logic [SAW-1:0]              tree_raddr;
  slot_t                       tree_rdata;
  logic                        stash_we;
  logic [STW-1:0]              stash_waddr;
  entry_t                      stash_wdata;
  logic [STW-1:0]              stash_raddr;
  entry_t                      stash_rdata;

  // Slot index of slot k in the path bucket at a given depth toward a leaf.
  function automatic logic [SAW-1:0] slot_addr(logic [DEPW-1:0] dep, logic [LW-1:0] lf,
                                               logic [ZW-1:0] k);
    logic [SAW:0] node;
    node = ((SAW+1)'(1) << dep) - (SAW+1)'(1) + (SAW+1)'(lf >> (LW - 32'(dep)));
    return SAW'(node * (SAW+1)'(SLOTS_PER_BUCKET)) + SAW'(k);
  endfunction

  // The address wraps modulo ADDRESS_COUNT; it is narrow, so eight conditional
  // subtractions cover every case for an ADDRESS_COUNT of two or more.
  always_comb begin
    logic [poa_pkg::ADDR_W:0] am;
    am = {1'b0, address_i};
    for (int i = 0; i < 8; i++) begin
      if (32'(am) >= ADDRESS_COUNT) begin
        am = (poa_pkg::ADDR_W+1)'(32'(am) - ADDRESS_COUNT);
      end
    end
    addr_in = am[poa_pkg::ADDR_W-1:0];
  end

  assign in_fire    = in_valid_i && !in_stall_o;
  assign fetch_done = iss_done_q && !pend_q;
  assign scan_done  = (idx_q >= fill_q) && !pend_q;
  assign pad_done   = (n_q == ZW'(SLOTS_PER_BUCKET));
  assign out_free   = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      poa_pkg::ST_CLEAR: begin
        if (clr_q == SAW'(SLOT_COUNT - 1)) state_d = poa_pkg::ST_IDLE;
      end
      poa_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = poa_pkg::ST_FETCH;
      end
      poa_pkg::ST_FETCH: begin
        if (fetch_done) state_d = poa_pkg::ST_LOOKUP;
      end
      poa_pkg::ST_LOOKUP: begin
        if (scan_done) state_d = poa_pkg::ST_INSERT;
      end
      poa_pkg::ST_INSERT: begin
        state_d = poa_pkg::ST_EVICT;
      end
      poa_pkg::ST_EVICT: begin
        if (scan_done) state_d = poa_pkg::ST_PAD;
      end
      poa_pkg::ST_PAD: begin
        if (pad_done) begin
          state_d = (lvl_q == '0) ? poa_pkg::ST_FINISH : poa_pkg::ST_EVICT;
        end
      end
      poa_pkg::ST_FINISH: begin
        if (out_free) state_d = poa_pkg::ST_IDLE;
      end
      default: state_d = poa_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    logic match;
    match       = 1'b0;
    leaf_map_d  = leaf_map_q;
    clr_d       = clr_q;
    mode_d      = mode_q;
    addr_d      = addr_q;
    wdata_d     = wdata_q;
    nleaf_d     = nleaf_q;
    x_d         = x_q;
    lvl_d       = lvl_q;
    k_d         = k_q;
    iss_done_d  = iss_done_q;
    pend_d      = pend_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    w_d         = w_q;
    n_d         = n_q;
    hit_d       = hit_q;
    rdata_d     = rdata_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_ovf_d   = out_ovf_q;
    tree_we     = 1'b0;
    tree_waddr  = '0;
    tree_wdata  = '0;
    tree_raddr  = '0;
    stash_we    = 1'b0;
    stash_waddr = '0;
    stash_wdata = '0;
    stash_raddr = '0;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      poa_pkg::ST_CLEAR: begin
        tree_we    = 1'b1;
        tree_waddr = clr_q;
        clr_d      = clr_q + SAW'(1);
      end
      poa_pkg::ST_IDLE: begin
        if (in_fire) begin
          mode_d              = mode_i;
          addr_d              = addr_in;
          wdata_d             = write_data_i[DW-1:0];
          nleaf_d             = LW'(new_leaf_i);
          x_d                 = leaf_map_q[addr_in];
          leaf_map_d[addr_in] = LW'(new_leaf_i);
          lvl_d               = DEPW'(LW);
          k_d                 = '0;
          iss_done_d          = 1'b0;
          pend_d              = 1'b0;
        end
      end
      poa_pkg::ST_FETCH: begin
        if (!iss_done_q) begin
          tree_raddr = slot_addr(lvl_q, x_q, k_q);
          pend_d     = 1'b1;
          if (k_q == ZW'(SLOTS_PER_BUCKET - 1)) begin
            k_d = '0;
            if (lvl_q == '0) iss_done_d = 1'b1;
            else lvl_d = lvl_q - DEPW'(1);
          end else begin
            k_d = k_q + ZW'(1);
          end
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && tree_rdata.valid) begin
          if (fill_q == FW'(STASH_DEPTH)) begin
            ovf_d = 1'b1;
          end else begin
            stash_we    = 1'b1;
            stash_waddr = fill_q[STW-1:0];
            stash_wdata = tree_rdata.ent;
            fill_d      = fill_q + FW'(1);
          end
        end
        if (fetch_done) begin
          idx_d  = '0;
          pend_d = 1'b0;
          hit_d  = 1'b0;
          rdata_d = '0;
        end
      end
      poa_pkg::ST_LOOKUP: begin
        if (idx_q < fill_q) begin
          stash_raddr = idx_q[STW-1:0];
          pend_d      = 1'b1;
          pos_d       = idx_q[STW-1:0];
          idx_d       = idx_q + FW'(1);
        end else begin
          pend_d = 1'b0;
        end
        // Every stash copy of the address takes the new leaf; only the first is served.
        if (pend_q && stash_rdata.tag == addr_q) begin
          stash_we         = 1'b1;
          stash_waddr      = pos_q;
          stash_wdata      = stash_rdata;
          stash_wdata.leaf = nleaf_q;
          if (!hit_q) begin
            hit_d = 1'b1;
            if (mode_q) stash_wdata.data = wdata_q;
            else rdata_d = stash_rdata.data;
          end
        end
      end
      poa_pkg::ST_INSERT: begin
        if (!hit_q) begin
          if (fill_q == FW'(STASH_DEPTH)) begin
            ovf_d = 1'b1;
          end else begin
            stash_we         = 1'b1;
            stash_waddr      = fill_q[STW-1:0];
            stash_wdata.tag  = addr_q;
            stash_wdata.leaf = nleaf_q;
            stash_wdata.data = mode_q ? wdata_q : '0;
            fill_d           = fill_q + FW'(1);
          end
        end
        lvl_d  = DEPW'(LW);
        idx_d  = '0;
        w_d    = '0;
        n_d    = '0;
        pend_d = 1'b0;
      end
      poa_pkg::ST_EVICT: begin
        if (idx_q < fill_q) begin
          stash_raddr = idx_q[STW-1:0];
          pend_d      = 1'b1;
          pos_d       = idx_q[STW-1:0];
          idx_d       = idx_q + FW'(1);
        end else begin
          pend_d = 1'b0;
        end
        // Kept entries are compacted toward the front; the write pointer never passes
        // the read pointer.
        if (pend_q) begin
          match = (n_q < ZW'(SLOTS_PER_BUCKET)) &&
                  (((stash_rdata.leaf ^ x_q) >> (LW - 32'(lvl_q))) == '0);
          if (match) begin
            tree_we          = 1'b1;
            tree_waddr       = slot_addr(lvl_q, x_q, n_q);
            tree_wdata.valid = 1'b1;
            tree_wdata.ent   = stash_rdata;
            n_d              = n_q + ZW'(1);
          end else begin
            stash_we    = 1'b1;
            stash_waddr = w_q[STW-1:0];
            stash_wdata = stash_rdata;
            w_d         = w_q + FW'(1);
          end
        end
        if (scan_done) fill_d = w_q;
      end
      poa_pkg::ST_PAD: begin
        if (!pad_done) begin
          tree_we    = 1'b1;
          tree_waddr = slot_addr(lvl_q, x_q, n_q);
          n_d        = n_q + ZW'(1);
        end else if (lvl_q != '0) begin
          lvl_d  = lvl_q - DEPW'(1);
          idx_d  = '0;
          w_d    = '0;
          n_d    = '0;
          pend_d = 1'b0;
        end
      end
      poa_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = mode_q ? '0 : rdata_q;
          out_ovf_d   = ovf_q;
        end
      end
      default: begin
        clr_d = '0;
      end
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall_o       = (state_q != poa_pkg::ST_IDLE);
    out_valid_o      = out_valid_q;
    read_data_o      = poa_pkg::DATA_W'(out_data_q);
    stash_overflow_o = out_ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= poa_pkg::ST_CLEAR;
      for (int i = 0; i < MAP_DEPTH; i++) leaf_map_q[i] <= '0;
      clr_q       <= '0;
      lvl_q       <= '0;
      k_q         <= '0;
      iss_done_q  <= 1'b0;
      pend_q      <= 1'b0;
      idx_q       <= '0;
      w_q         <= '0;
      n_q         <= '0;
      hit_q       <= 1'b0;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      leaf_map_q  <= leaf_map_d;
      clr_q       <= clr_d;
      lvl_q       <= lvl_d;
      k_q         <= k_d;
      iss_done_q  <= iss_done_d;
      pend_q      <= pend_d;
      idx_q       <= idx_d;
      w_q         <= w_d;
      n_q         <= n_d;
      hit_q       <= hit_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    addr_q     <= addr_d;
    wdata_q    <= wdata_d;
    nleaf_q    <= nleaf_d;
    x_q        <= x_d;
    pos_q      <= pos_d;
    rdata_q    <= rdata_d;
    out_data_q <= out_data_d;
  end

  poa_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(SLOT_COUNT)
  ) u_tree_ram (
    .clk_i  (clk_i),
    .we_i   (tree_we),
    .waddr_i(tree_waddr),
    .wdata_i(tree_wdata),
    .raddr_i(tree_raddr),
    .rdata_o(tree_rdata)
  );

  poa_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(STASH_DEPTH)
  ) u_stash_ram (
    .clk_i  (clk_i),
    .we_i   (stash_we),
    .waddr_i(stash_waddr),
    .wdata_i(stash_wdata),
    .raddr_i(stash_raddr),
    .rdata_o(stash_rdata)
  );

  `POA_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= FW'(STASH_DEPTH), "fill high")
  `POA_ASSERT_IMP(a_bucket_bound, clk_i, rst_ni, 1'b1, n_q <= ZW'(SLOTS_PER_BUCKET), "bucket")
  `POA_ASSERT_IMP(a_ovf_sticky, clk_i, rst_ni, $past(ovf_q), ovf_q, "overflow flag cleared")
  `POA_ASSERT_NXT(a_accept_fetch, clk_i, rst_ni, in_fire, state_q == poa_pkg::ST_FETCH, "no fetch")

endmodule

/* tb/sv/path_oram_access_core_tb.sv */
// Testbench for the path ORAM access core: directed and random requests against a predictor.
`timescale 1ns / 100ps

module path_oram_access_core_tb;

  localparam int LEVELS      = 4;
  localparam int SLOTS       = 4;
  localparam int STASH_MAX   = 32;
  localparam int ADDRS       = 16;
  localparam int NODES       = (1 << LEVELS) - 1;
  localparam int SLOT_TOTAL  = NODES * SLOTS;
  localparam int IDLE_LIMIT  = 4000;

  typedef struct packed {
    logic [poa_pkg::DATA_W-1:0] read_data;
    logic                       overflow;
  } access_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic                           mode_i = 1'b0;
  logic [poa_pkg::ADDR_W-1:0]     address_i = '0;
  logic [poa_pkg::DATA_W-1:0]     write_data_i = '0;
  logic [poa_pkg::LEAF_IN_W-1:0]  new_leaf_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [poa_pkg::DATA_W-1:0]     read_data_o;
  logic                           stash_overflow_o;

  path_oram_access_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .address_i, .write_data_i,
    .new_leaf_i, .out_valid_o, .out_stall_i, .read_data_o, .stash_overflow_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the ORAM state.
  logic [2:0]                 leaf_of [ADDRS];
  logic                       slot_live [SLOT_TOTAL];
  logic [4:0]                 slot_addr [SLOT_TOTAL];
  logic [poa_pkg::DATA_W-1:0] slot_data [SLOT_TOTAL];
  logic [4:0]                 stash_addr [STASH_MAX];
  logic [poa_pkg::DATA_W-1:0] stash_data [STASH_MAX];
  int                         stash_count = 0;
  logic                       overflow_flag = 1'b0;

  access_result_t pending_results[$];
  int  mismatches = 0;
  int  requests_sent = 0;
  int  results_seen = 0;
  int  reads_sent = 0;
  int  writes_sent = 0;
  bit  busy_sides = 1'b1;
  int  quiet_cycles = 0;
  int  recv_wait = 0;

  task automatic shadow_push(input logic [4:0] a, input logic [poa_pkg::DATA_W-1:0] v);
    if (stash_count >= STASH_MAX) begin
      overflow_flag = 1'b1;
    end else begin
      stash_addr[stash_count] = a;
      stash_data[stash_count] = v;
      stash_count++;
    end
  endtask

  task automatic predict_access(input logic m, input logic [3:0] a,
                                input logic [63:0] wd, input logic [2:0] nl);
    logic [2:0]  old_leaf;
    logic [63:0] rd;
    int          node, base, sh, n, k, j, hit_pos;
    access_result_t res;
    rd = '0;
    old_leaf = leaf_of[a];
    leaf_of[a] = nl;
    for (int d = LEVELS - 1; d >= 0; d--) begin
      node = ((1 << d) - 1) + (old_leaf >> (LEVELS - 1 - d));
      base = node * SLOTS;
      for (k = 0; k < SLOTS; k++) begin
        if (slot_live[base + k]) begin
          shadow_push(slot_addr[base + k], slot_data[base + k]);
          slot_live[base + k] = 1'b0;
        end
      end
    end
    hit_pos = -1;
    for (k = 0; k < stash_count; k++) begin
      if (hit_pos < 0 && stash_addr[k] == {1'b0, a}) hit_pos = k;
    end
    if (!m) begin
      if (hit_pos >= 0) rd = stash_data[hit_pos];
      else shadow_push({1'b0, a}, '0);
    end else begin
      if (hit_pos >= 0) stash_data[hit_pos] = wd;
      else shadow_push({1'b0, a}, wd);
    end
    for (int d = LEVELS - 1; d >= 0; d--) begin
      sh = LEVELS - 1 - d;
      node = ((1 << d) - 1) + (old_leaf >> sh);
      base = node * SLOTS;
      n = 0;
      k = 0;
      while (k < stash_count && n < SLOTS) begin
        if ((leaf_of[stash_addr[k][3:0]] >> sh) == (old_leaf >> sh)) begin
          slot_live[base + n] = 1'b1;
          slot_addr[base + n] = stash_addr[k];
          slot_data[base + n] = stash_data[k];
          n++;
          for (j = k; j < stash_count - 1; j++) begin
            stash_addr[j] = stash_addr[j + 1];
            stash_data[j] = stash_data[j + 1];
          end
          stash_count--;
        end else begin
          k++;
        end
      end
      for (; n < SLOTS; n++) slot_live[base + n] = 1'b0;
    end
    res.read_data = rd;
    res.overflow = overflow_flag;
    pending_results.push_back(res);
  endtask

  // Sends one request; valid stays high when the next one follows without a gap.
  task automatic send_access(input logic m, input logic [3:0] a,
                             input logic [63:0] wd, input logic [2:0] nl);
    int gap;
    gap = busy_sides ? int'($urandom_range(0, 5)) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    address_i    <= a;
    write_data_i <= wd;
    new_leaf_i   <= nl;
    do @(posedge clk_i); while (in_stall_o);
    predict_access(m, a, wd, nl);
    requests_sent++;
    if (m) writes_sent++;
    else reads_sent++;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Receiver: random stall, result check and watchdog.
  always @(posedge clk_i) begin
    access_result_t exp_res;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("path_oram_access_core: mismatch");
      $finish;
    end
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: data %h ovf %b",
                                       read_data_o, stash_overflow_o);
      end else begin
        exp_res = pending_results.pop_front();
        if (read_data_o !== exp_res.read_data || stash_overflow_o !== exp_res.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected data %h ovf %b, got data %h ovf %b",
                     results_seen, exp_res.read_data, exp_res.overflow,
                     read_data_o, stash_overflow_o);
        end
      end
      recv_wait = busy_sides ? int'($urandom_range(0, 5)) : 0;
    end
    if (recv_wait > 0) begin
      out_stall_i <= 1'b1;
      recv_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Reads before any write must miss and return zero.
  task automatic test_cold_reads();
    send_access(1'b0, 4'd0, rand_word(), 3'd0);
    send_access(1'b0, 4'd15, rand_word(), 3'd7);
    send_access(1'b0, 4'd5, '0, 3'd2);
    send_access(1'b0, 4'd10, '1, 3'd5);
  endtask

  task automatic test_write_extremes();
    send_access(1'b1, 4'd0, '0, 3'd7);
    send_access(1'b1, 4'd15, '1, 3'd0);
    send_access(1'b1, 4'd1, 64'h5555_5555_5555_5555, 3'd1);
    send_access(1'b1, 4'd2, 64'hAAAA_AAAA_AAAA_AAAA, 3'd6);
    send_access(1'b1, 4'd0, 64'h8000_0000_0000_0001, 3'd3);
    send_access(1'b1, 4'd6, rand_word(), 3'd4);
    send_access(1'b1, 4'd15, rand_word(), 3'd7);
    send_access(1'b1, 4'd9, rand_word(), 3'd0);
  endtask

  // Hits on freshly written blocks, plus a read miss on a never-written address.
  task automatic test_read_back();
    send_access(1'b0, 4'd0, rand_word(), 3'd0);
    send_access(1'b0, 4'd15, rand_word(), 3'd7);
    send_access(1'b0, 4'd1, rand_word(), 3'd2);
    send_access(1'b0, 4'd2, rand_word(), 3'd5);
    send_access(1'b0, 4'd6, rand_word(), 3'd1);
    send_access(1'b0, 4'd9, rand_word(), 3'd6);
    send_access(1'b0, 4'd12, rand_word(), 3'd3);
    send_access(1'b0, 4'd12, rand_word(), 3'd4);
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      // Stretches with no gaps and no stalls break up the randomly idling traffic.
      if (i % 100 == 0) busy_sides = ($urandom_range(0, 3) != 0);
      send_access(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), rand_word(),
                  3'($urandom_range(0, 7)));
    end
    busy_sides = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < ADDRS; i++) leaf_of[i] = '0;
    for (int i = 0; i < SLOT_TOTAL; i++) slot_live[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_cold_reads();
    test_write_extremes();
    test_read_back();
    test_random_traffic(830);
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    $display("Ran %0d accesses (%0d reads, %0d writes); %0d results checked.",
             requests_sent, reads_sent, writes_sent, results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("path_oram_access_core: match");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("path_oram_access_core: mismatch");
    end
    $finish;
  end

endmodule
